// ===== rtl/sbb_pkg.sv =====
// Package for the separable box blur block: item types, codes, widths and
// the control structs passed between the sequencer and the datapath.
// No dependencies; the sequencer, datapath and top level import it.
package sbb_pkg;

  // Default frame limits, handed to the top-level parameters
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Field and datapath widths
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 9;   // image_width / image_height registers
  localparam int RAD_W      = 7;   // radius register
  localparam int DIM_W      = 13;  // holds any dimension up to 4096 and any 9-bit value
  localparam int POS_W      = DIM_W + 1;  // signed window position
  localparam int SUM_W      = 16;  // window sum, at most 254 * 255
  localparam int QUOT_W     = 8;   // quotient bits
  localparam int DIV_STAGES = QUOT_W;  // one quotient bit per divider stage
  localparam int CFG_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Request action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SKIP  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       column;
    logic [7:0]       row_index;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [1:0]       status;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_INIT,
    SEQ_SUB,
    SEQ_ADD,
    SEQ_DRAIN
  } seq_state_t;

  // Accumulator operation carried with each memory read
  typedef enum logic [1:0] {
    ACC_LOAD,   // first pixel of a line: sum = pixel
    ACC_ADD,    // prime the window
    ACC_SUB,    // pixel leaving the window
    ACC_EMIT    // pixel entering the window, then divide and store
  } acc_op_t;

  typedef struct packed {
    logic    valid;
    acc_op_t op;
    logic    pass;   // 0 row pass, 1 column pass
  } seq_req_t;

  typedef struct packed {
    logic             valid;
    logic             pass;
    logic [PIX_W-1:0] data;
  } dp_wr_t;

endpackage

// ===== rtl/sbb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module sbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sbb_seq.sv =====
// Blur sequencer: walks every row, then every column; except while draining, it
// issues one read per cycle, with accumulator op and store address. Uses sbb_pkg.
module sbb_seq #(
  parameter int MAX_WIDTH  = sbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sbb_pkg::DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int AW = CW + RW
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sbb_pkg::DIM_W-1:0] eff_w,
  input  logic [sbb_pkg::DIM_W-1:0] eff_h,
  input  logic [sbb_pkg::RAD_W-1:0] radius,
  input  logic                      pipe_busy,
  output logic                      busy,
  output sbb_pkg::seq_req_t         req,
  output logic [AW-1:0]             raddr,
  output logic [AW-1:0]             waddr
);
  import sbb_pkg::*;

  seq_state_t              state_r, state_nxt;
  logic                    pass_r, pass_nxt;
  logic [DIM_W-1:0]        line_r, line_nxt;
  logic [DIM_W-1:0]        idx_r, idx_nxt;
  logic signed [POS_W-1:0] pos_r, pos_nxt;

  logic [DIM_W-1:0]        len, lines, cl;
  logic signed [POS_W-1:0] rad_s, idx_s, rd_pos;

  assign rad_s = $signed(POS_W'(radius));
  assign idx_s = $signed(POS_W'(idx_r));
  assign len   = pass_r ? eff_h : eff_w;
  assign lines = pass_r ? eff_w : eff_h;

  // Window position of this cycle's read, clamped to the line
  always_comb begin
    case (state_r)
      SEQ_INIT: rd_pos = pos_r;
      SEQ_SUB:  rd_pos = idx_s - rad_s;
      default:  rd_pos = idx_s + rad_s;
    endcase
    if (rd_pos < 0) begin
      cl = '0;
    end else if (rd_pos >= $signed({1'b0, len})) begin
      cl = len - DIM_W'(1);
    end else begin
      cl = DIM_W'(rd_pos);
    end
  end

  // Row pass: line is the row; column pass: line is the column
  always_comb begin
    if (pass_r) begin
      raddr = {cl[RW-1:0], line_r[CW-1:0]};
      waddr = {idx_r[RW-1:0], line_r[CW-1:0]};
    end else begin
      raddr = {line_r[RW-1:0], cl[CW-1:0]};
      waddr = {line_r[RW-1:0], idx_r[CW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pass_r  <= 1'b0;
      line_r  <= '0;
      idx_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      line_r  <= line_nxt;
      idx_r   <= idx_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Next state and read requests
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    line_nxt  = line_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    req.valid = 1'b0;
    req.op    = ACC_ADD;
    req.pass  = pass_r;
    case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_INIT;
          pass_nxt  = 1'b0;
          line_nxt  = '0;
          pos_nxt   = -rad_s;
        end
      end
      SEQ_INIT: begin
        // prime the window with positions -r .. r-1
        req.valid = 1'b1;
        req.op    = (pos_r == -rad_s) ? ACC_LOAD : ACC_ADD;
        if (pos_r == rad_s - POS_W'(1)) begin
          state_nxt = SEQ_SUB;
          idx_nxt   = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      SEQ_SUB: begin
        req.valid = 1'b1;
        req.op    = ACC_SUB;
        state_nxt = SEQ_ADD;
      end
      SEQ_ADD: begin
        req.valid = 1'b1;
        req.op    = ACC_EMIT;
        if (idx_r == len - DIM_W'(1)) begin
          if (line_r == lines - DIM_W'(1)) begin
            state_nxt = SEQ_DRAIN;
          end else begin
            line_nxt  = line_r + DIM_W'(1);
            pos_nxt   = -rad_s;
            state_nxt = SEQ_INIT;
          end
        end else begin
          idx_nxt   = idx_r + DIM_W'(1);
          state_nxt = SEQ_SUB;
        end
      end
      SEQ_DRAIN: begin
        // column pass reads what the row pass wrote: wait for the last store
        if (!pipe_busy) begin
          if (!pass_r) begin
            pass_nxt  = 1'b1;
            line_nxt  = '0;
            pos_nxt   = -rad_s;
            state_nxt = SEQ_INIT;
          end else begin
            state_nxt = SEQ_IDLE;
          end
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  assign busy = (state_r != SEQ_IDLE);

endmodule

// ===== rtl/sbb_dp.sv =====
// Blur datapath: running window sum over the memory read stream, then an
// eight-stage restoring divider by 2*radius feeding the store. Uses sbb_pkg.
module sbb_dp #(
  parameter int AW = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sbb_pkg::seq_req_t         req,
  input  logic [AW-1:0]             waddr,
  input  logic [sbb_pkg::PIX_W-1:0] src_rdata,
  input  logic [sbb_pkg::PIX_W-1:0] part_rdata,
  input  logic [sbb_pkg::RAD_W-1:0] radius,
  output sbb_pkg::dp_wr_t           wr,
  output logic [AW-1:0]             wr_addr,
  output logic                      busy
);
  import sbb_pkg::*;

  // Request tag, aligned with the RAM read data
  logic             t_valid_r;
  acc_op_t          t_op_r;
  logic             t_pass_r;
  logic [AW-1:0]    t_addr_r;

  logic [PIX_W-1:0] rd_pix;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] divisor;

  logic [DIV_STAGES:0] div_valid_r;
  logic [SUM_W-1:0]    div_rem_r  [DIV_STAGES+1];
  logic [QUOT_W-1:0]   div_q_r    [DIV_STAGES+1];
  logic [AW-1:0]       div_addr_r [DIV_STAGES+1];
  logic                div_pass_r [DIV_STAGES+1];

  logic [SUM_W-1:0]    step_sh  [DIV_STAGES];
  logic [SUM_W-1:0]    step_rem [DIV_STAGES];
  logic [QUOT_W-1:0]   step_q   [DIV_STAGES];

  assign rd_pix  = t_pass_r ? part_rdata : src_rdata;
  assign divisor = SUM_W'({radius, 1'b0});

  // Window sum update
  always_comb begin
    case (t_op_r)
      ACC_LOAD: sum_nxt = SUM_W'(rd_pix);
      ACC_SUB:  sum_nxt = sum_r - SUM_W'(rd_pix);
      default:  sum_nxt = sum_r + SUM_W'(rd_pix);
    endcase
  end

  // One compare-subtract per stage, most significant quotient bit first
  always_comb begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      step_sh[j] = divisor << (DIV_STAGES - 1 - j);
      if (div_rem_r[j] >= step_sh[j]) begin
        step_rem[j] = div_rem_r[j] - step_sh[j];
        step_q[j]   = div_q_r[j] | (QUOT_W'(1) << (DIV_STAGES - 1 - j));
      end else begin
        step_rem[j] = div_rem_r[j];
        step_q[j]   = div_q_r[j];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_valid_r   <= 1'b0;
      div_valid_r <= '0;
    end else begin
      t_valid_r   <= req.valid;
      div_valid_r <= {div_valid_r[DIV_STAGES-1:0], t_valid_r && (t_op_r == ACC_EMIT)};
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    t_op_r   <= req.op;
    t_pass_r <= req.pass;
    t_addr_r <= waddr;
    if (t_valid_r) begin
      sum_r <= sum_nxt;
    end
    div_rem_r[0]  <= sum_nxt;
    div_q_r[0]    <= '0;
    div_addr_r[0] <= t_addr_r;
    div_pass_r[0] <= t_pass_r;
    for (int j = 0; j < DIV_STAGES; j++) begin
      div_rem_r[j+1]  <= step_rem[j];
      div_q_r[j+1]    <= step_q[j];
      div_addr_r[j+1] <= div_addr_r[j];
      div_pass_r[j+1] <= div_pass_r[j];
    end
  end

  assign wr.valid = div_valid_r[DIV_STAGES];
  assign wr.pass  = div_pass_r[DIV_STAGES];
  assign wr.data  = div_q_r[DIV_STAGES];
  assign wr_addr  = div_addr_r[DIV_STAGES];
  assign busy     = t_valid_r || (|div_valid_r);

endmodule

// ===== rtl/separable_box_blur.sv =====
// Separable box blur top level: APB registers, request/result channels,
// the three frame memories, sequencer and datapath. Uses sbb_pkg, sbb_ram,
// sbb_seq and sbb_dp.
//
// Usage: load source pixels with write requests (action 0), start a blur
// with a run request (action 1), fetch blurred pixels with read requests
// (action 2). Every request gives exactly one result on the out_ channel.
// Frame size and radius are set over the APB port (width at 0x0, height at
// 0x4, radius at 0x8) while the block is idle.
// Write and read requests: one per cycle while out_ready stays high; the
// result passes the pending stage (RAM read) and the output register.
// Run requests: the sequencer reads one pixel per cycle from one RAM read
// port, pausing after each pass until the divider pipeline drains; each
// line takes 2r priming reads, then two reads per pixel (leaving and
// entering the window). in_ready stays low meanwhile. A run with radius 0,
// or on a frame under 2r+1 in either direction, returns status 1 at once.
// Reset clears the registers to 256 x 256, radius 1, and empties the
// pipeline; frame memory contents are undefined until written.
// A stalled receiver holds the output register; one more request is taken
// into the pending stage, then in_ready drops until out_ready returns.
module separable_box_blur #(
  parameter int MAX_WIDTH  = sbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sbb_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sbb_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sbb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sbb_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sbb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;

  logic [CFG_W-1:0] image_width_r, image_height_r;
  logic [RAD_W-1:0] radius_r;
  logic [1:0]       reg_idx;
  logic             cfg_wr;

  logic [DIM_W-1:0] eff_w, eff_h, col_d, row_d, min_dim;
  logic             in_range, run_skip, in_acc;
  logic [AW-1:0]    host_addr;
  logic             src_we, res_re, run_go;

  logic             p_valid_r, p_read_r, p_move;
  logic [1:0]       p_status_r, p_status_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             seq_busy, dp_busy;
  seq_req_t         seq_req;
  logic [AW-1:0]    seq_raddr, seq_waddr, dp_waddr;
  dp_wr_t           dp_wr;
  logic [PIX_W-1:0] src_rdata, part_rdata, res_rdata;

  // APB register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= CFG_W'(256);
      image_height_r <= CFG_W'(256);
      radius_r       <= RAD_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:  image_width_r  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: image_height_r <= pwdata[CFG_W-1:0];
        REG_RADIUS: radius_r       <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = APB_DATA_W'(image_width_r);
      REG_HEIGHT: prdata = APB_DATA_W'(image_height_r);
      REG_RADIUS: prdata = APB_DATA_W'(radius_r);
      default:    prdata = '0;
    endcase
  end

  // Effective frame size, limited by the memory geometry
  assign eff_w = (DIM_W'(image_width_r) > DIM_W'(MAX_WIDTH)) ?
                 DIM_W'(MAX_WIDTH) : DIM_W'(image_width_r);
  assign eff_h = (DIM_W'(image_height_r) > DIM_W'(MAX_HEIGHT)) ?
                 DIM_W'(MAX_HEIGHT) : DIM_W'(image_height_r);
  assign min_dim  = DIM_W'({radius_r, 1'b1});  // 2r+1
  assign run_skip = (radius_r == '0) || (eff_w < min_dim) || (eff_h < min_dim);

  // Host request decode
  assign col_d     = DIM_W'(in_data.column);
  assign row_d     = DIM_W'(in_data.row_index);
  assign in_range  = (col_d < eff_w) && (row_d < eff_h);
  assign host_addr = {row_d[RW-1:0], col_d[CW-1:0]};
  assign in_acc    = in_valid && in_ready;
  assign src_we    = in_acc && (in_data.action == ACT_WRITE) && in_range;
  assign res_re    = in_acc && (in_data.action == ACT_READ) && in_range;
  assign run_go    = in_acc && (in_data.action == ACT_RUN) && !run_skip;

  always_comb begin
    case (in_data.action)
      ACT_WRITE, ACT_READ: p_status_nxt = in_range ? ST_OK : ST_RANGE;
      ACT_RUN:             p_status_nxt = run_skip ? ST_SKIP : ST_OK;
      default:             p_status_nxt = ST_OK;
    endcase
  end

  // Pending stage (RAM read) waits for a finished run and a free output
  assign p_move   = p_valid_r && (!out_valid_r || out_ready) && !seq_busy;
  assign in_ready = !seq_busy && (!p_valid_r || p_move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        p_valid_r <= 1'b1;
      end else if (p_move) begin
        p_valid_r <= 1'b0;
      end
      if (p_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_read_r   <= res_re;
      p_status_r <= p_status_nxt;
    end
    if (p_move) begin
      out_data_r.pixel_out <= p_read_r ? res_rdata : '0;
      out_data_r.status    <= p_status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Run engine
  sbb_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (run_go),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .radius    (radius_r),
    .pipe_busy (dp_busy),
    .busy      (seq_busy),
    .req       (seq_req),
    .raddr     (seq_raddr),
    .waddr     (seq_waddr)
  );

  sbb_dp #(
    .AW (AW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (seq_req),
    .waddr      (seq_waddr),
    .src_rdata  (src_rdata),
    .part_rdata (part_rdata),
    .radius     (radius_r),
    .wr         (dp_wr),
    .wr_addr    (dp_waddr),
    .busy       (dp_busy)
  );

  // Frame memories: source (host in, row pass out), partial (row pass in,
  // column pass out), result (column pass in, host out)
  sbb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (1 << AW)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (host_addr),
    .wdata (in_data.pixel_in),
    .re    (seq_req.valid && !seq_req.pass),
    .raddr (seq_raddr),
    .rdata (src_rdata)
  );

  sbb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (1 << AW)
  ) u_part_ram (
    .clk   (clk),
    .we    (dp_wr.valid && !dp_wr.pass),
    .waddr (dp_waddr),
    .wdata (dp_wr.data),
    .re    (seq_req.valid && seq_req.pass),
    .raddr (seq_raddr),
    .rdata (part_rdata)
  );

  sbb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (1 << AW)
  ) u_res_ram (
    .clk   (clk),
    .we    (dp_wr.valid && dp_wr.pass),
    .waddr (dp_waddr),
    .wdata (dp_wr.data),
    .re    (res_re),
    .raddr (host_addr),
    .rdata (res_rdata)
  );

  // Checks
  a_src_quiet_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    seq_busy |-> !src_we)
    else $error("source memory written during a run");

  a_store_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    dp_wr.valid |-> seq_busy)
    else $error("blur store write outside a run");

  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    run_go |=> seq_busy)
    else $error("accepted run did not start the sequencer");

  a_pipe_empty_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !seq_busy |-> !dp_busy)
    else $error("datapath busy while sequencer idle");

endmodule
